// ===== rtl/mvpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Move point towards target: shared types and constants
// Coordinate format, internal widths and the request and result structs.
// ----------------------------------------------------------------------------
package mvpt_pkg;

  // Coordinate width in bits (signed Q16.16 by default).
  localparam int CoordW = 32;
  // Width of a per-axis difference magnitude.
  localparam int DiffW  = CoordW + 1;
  // Width of the sum of three squared differences.
  localparam int SqW    = 2 * DiffW + 2;
  // Width of the integer square root of that sum.
  localparam int RootW  = SqW / 2;
  // Width of one per-axis product of difference and step magnitudes.
  localparam int NumW   = DiffW + CoordW;
  // Width of one per-axis move; the move never exceeds the step magnitude.
  localparam int QuoW   = CoordW;

  typedef logic signed [CoordW-1:0] coord_t;

  // Input request.
  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    coord_t cur_z;
    coord_t tgt_x;
    coord_t tgt_y;
    coord_t tgt_z;
    coord_t max_step;
  } req_t;

  // Result.
  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   reached;
  } rsp_t;

  // Data that rides alongside the square root pipeline.
  typedef struct packed {
    coord_t [2:0]             cur;
    coord_t [2:0]             tgt;
    logic   [2:0][DiffW-1:0]  ad;
    logic   [2:0]             neg;
    logic   [CoordW-1:0]      astep;
    logic                     reached;
  } root_side_t;

  // Data that rides alongside the divider pipeline.
  typedef struct packed {
    coord_t [2:0] cur;
    coord_t [2:0] tgt;
    logic   [2:0] neg;
    logic         reached;
  } div_side_t;

endpackage

// ===== rtl/move_point_towards_target_unit.sv =====
// ----------------------------------------------------------------------------
// Move point towards target
// Steps a 3-D Q16.16 point towards a target by at most a given distance.
// ----------------------------------------------------------------------------
// The unit takes one request per cycle while in_stall_o is low and returns
// results in request order. With 32-bit coordinates a request passes the
// difference, square, sum and compare stages, 34 square-root stages (one root
// bit each), one product stage, 32 divider stages (one quotient bit each) and
// a saturation stage before the output register. A two-entry output buffer
// lets a request enter while a finished result waits; once both entries are
// full the whole pipeline holds and in_stall_o rises. Coordinates are exact
// integer fixed point: the distance is the floor square root and each move is
// truncated towards zero before saturation.
module move_point_towards_target_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mvpt_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mvpt_pkg::rsp_t out_rsp_o
);

  localparam int W     = mvpt_pkg::CoordW;
  localparam int DiffW = mvpt_pkg::DiffW;
  localparam int SqW   = mvpt_pkg::SqW;
  localparam int RootW = mvpt_pkg::RootW;
  localparam int NumW  = mvpt_pkg::NumW;
  localparam int QuoW  = mvpt_pkg::QuoW;
  localparam int RootSideW = $bits(mvpt_pkg::root_side_t);
  localparam int DivSideW  = $bits(mvpt_pkg::div_side_t);

  logic en;

  // Stage 1: differences, magnitudes and move directions.
  logic                       s1_vld_q;
  mvpt_pkg::coord_t [2:0]     s1_cur_q, s1_tgt_q;
  logic [2:0][DiffW-1:0]      s1_ad_q;
  logic [2:0]                 s1_neg_q;
  logic [W-1:0]               s1_astep_q;
  logic                       s1_sneg_q;

  mvpt_pkg::coord_t [2:0]     in_cur, in_tgt;
  logic [2:0][DiffW-1:0]      s1_ad_d;
  logic [2:0]                 s1_neg_d;
  logic [W-1:0]               s1_astep_d;

  assign in_cur = {in_req_i.cur_z, in_req_i.cur_y, in_req_i.cur_x};
  assign in_tgt = {in_req_i.tgt_z, in_req_i.tgt_y, in_req_i.tgt_x};

  always_comb begin
    logic signed [DiffW-1:0] dif;
    for (int k = 0; k < 3; k++) begin
      dif = {in_tgt[k][W-1], in_tgt[k]} - {in_cur[k][W-1], in_cur[k]};
      s1_ad_d[k]  = dif[DiffW-1] ? DiffW'(-dif) : DiffW'(dif);
      s1_neg_d[k] = dif[DiffW-1] ^ in_req_i.max_step[W-1];
    end
    s1_astep_d = in_req_i.max_step[W-1] ? W'(-in_req_i.max_step) : W'(in_req_i.max_step);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_cur_q   <= in_cur;
      s1_tgt_q   <= in_tgt;
      s1_ad_q    <= s1_ad_d;
      s1_neg_q   <= s1_neg_d;
      s1_astep_q <= s1_astep_d;
      s1_sneg_q  <= in_req_i.max_step[W-1];
    end
  end

  // Stage 2: squared differences and squared step.
  logic                        s2_vld_q;
  logic [2:0][2*DiffW-1:0]     s2_sq_q;
  logic [2*W-1:0]              s2_st2_q;
  mvpt_pkg::root_side_t        s2_side_q;
  logic                        s2_sneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s2_sq_q[k] <= s1_ad_q[k] * s1_ad_q[k];
      end
      s2_st2_q          <= s1_astep_q * s1_astep_q;
      s2_side_q.cur     <= s1_cur_q;
      s2_side_q.tgt     <= s1_tgt_q;
      s2_side_q.ad      <= s1_ad_q;
      s2_side_q.neg     <= s1_neg_q;
      s2_side_q.astep   <= s1_astep_q;
      s2_side_q.reached <= 1'b0;
      s2_sneg_q         <= s1_sneg_q;
    end
  end

  // Stage 3: squared distance.
  logic                  s3_vld_q;
  logic [SqW-1:0]        s3_sum_q;
  logic [2*W-1:0]        s3_st2_q;
  mvpt_pkg::root_side_t  s3_side_q;
  logic                  s3_sneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_sum_q  <= SqW'(s2_sq_q[0]) + SqW'(s2_sq_q[1]) + SqW'(s2_sq_q[2]);
      s3_st2_q  <= s2_st2_q;
      s3_side_q <= s2_side_q;
      s3_sneg_q <= s2_sneg_q;
    end
  end

  // Stage 4: decide whether the target is reached outright.
  logic                  s4_vld_q;
  logic [SqW-1:0]        s4_sum_q;
  mvpt_pkg::root_side_t  s4_side_q;
  mvpt_pkg::root_side_t  s4_side_d;
  logic                  s4_reached;

  assign s4_reached = (s3_sum_q == '0) || (!s3_sneg_q && (s3_sum_q <= SqW'(s3_st2_q)));

  always_comb begin
    s4_side_d         = s3_side_q;
    s4_side_d.reached = s4_reached;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_sum_q  <= s3_sum_q;
      s4_side_q <= s4_side_d;
    end
  end

  // Distance as the floor square root of the squared distance.
  logic                  rt_vld;
  logic [RootW-1:0]      rt_root;
  logic [RootSideW-1:0]  rt_side_raw;
  mvpt_pkg::root_side_t  rt_side;

  mvpt_isqrt #(
    .SqW   (SqW),
    .SideW (RootSideW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s4_vld_q),
    .sq_i   (s4_sum_q),
    .side_i (RootSideW'(s4_side_q)),
    .vld_o  (rt_vld),
    .root_o (rt_root),
    .side_o (rt_side_raw)
  );

  assign rt_side = mvpt_pkg::root_side_t'(rt_side_raw);

  // Product stage: per-axis difference times step magnitude.
  logic                  sm_vld_q;
  logic [2:0][NumW-1:0]  sm_num_q;
  logic [RootW-1:0]      sm_den_q;
  mvpt_pkg::div_side_t   sm_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_vld_q <= 1'b0;
    end else if (en) begin
      sm_vld_q <= rt_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sm_num_q[k] <= rt_side.ad[k] * rt_side.astep;
      end
      sm_den_q          <= rt_root;
      sm_side_q.cur     <= rt_side.cur;
      sm_side_q.tgt     <= rt_side.tgt;
      sm_side_q.neg     <= rt_side.neg;
      sm_side_q.reached <= rt_side.reached;
    end
  end

  // Per-axis move magnitude: product divided by distance.
  logic                  dv_vld;
  logic [2:0][QuoW-1:0]  dv_quo;
  logic [DivSideW-1:0]   dv_side_raw;
  mvpt_pkg::div_side_t   dv_side;

  mvpt_div #(
    .Lanes (3),
    .NumW  (NumW),
    .DenW  (RootW),
    .QuoW  (QuoW),
    .SideW (DivSideW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sm_vld_q),
    .num_i  (sm_num_q),
    .den_i  (sm_den_q),
    .side_i (DivSideW'(sm_side_q)),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .side_o (dv_side_raw)
  );

  assign dv_side = mvpt_pkg::div_side_t'(dv_side_raw);

  // Final stage: apply direction, add and saturate, or pass the target.
  logic                   sf_vld_q;
  mvpt_pkg::rsp_t         sf_rsp_q;
  mvpt_pkg::coord_t [2:0] sf_pt;

  always_comb begin
    logic signed [W+1:0] mv;
    logic signed [W+1:0] sum;
    for (int k = 0; k < 3; k++) begin
      mv  = dv_side.neg[k] ? -$signed((W+2)'(dv_quo[k])) : $signed((W+2)'(dv_quo[k]));
      sum = {{2{dv_side.cur[k][W-1]}}, dv_side.cur[k]} + mv;
      if (dv_side.reached) begin
        sf_pt[k] = dv_side.tgt[k];
      end else if ((sum[W+1:W-1] == '0) || (sum[W+1:W-1] == '1)) begin
        sf_pt[k] = sum[W-1:0];
      end else if (sum[W+1]) begin
        sf_pt[k] = {1'b1, {(W-1){1'b0}}};
      end else begin
        sf_pt[k] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_vld_q <= 1'b0;
    end else if (en) begin
      sf_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sf_rsp_q.out_x   <= sf_pt[0];
      sf_rsp_q.out_y   <= sf_pt[1];
      sf_rsp_q.out_z   <= sf_pt[2];
      sf_rsp_q.reached <= dv_side.reached;
    end
  end

  // Output register plus skid entry; the pipeline holds while the skid is full.
  logic           out_vld_q, skid_vld_q;
  mvpt_pkg::rsp_t out_rsp_q, skid_rsp_q;
  logic           out_free;
  logic           push;

  assign en       = !skid_vld_q;
  assign out_free = !out_vld_q || !out_stall_i;
  assign push     = en && sf_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q  <= skid_vld_q || push;
      skid_vld_q <= 1'b0;
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_rsp_q <= skid_vld_q ? skid_rsp_q : sf_rsp_q;
    end else if (push) begin
      skid_rsp_q <= sf_rsp_q;
    end
  end

  assign in_stall_o  = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_rsp_q;

  // The skid entry is only ever occupied behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry holds a result while the output register is empty");

  // The skid entry fills only when the output was full and stalled.
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && out_stall_i))
    else $error("skid entry filled without an output stall");

  // A taken output with a full skid moves the skid result forward.
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_stall_i && skid_vld_q) |=> (out_vld_q && !skid_vld_q))
    else $error("skid result not forwarded after output was taken");

endmodule

// ===== rtl/mvpt_isqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per register stage, rounded down, with a sideband carried along.
// ----------------------------------------------------------------------------
module mvpt_isqrt #(
  parameter int SqW   = 68,
  parameter int SideW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [SqW-1:0]       sq_i,
  input  logic [SideW-1:0]     side_i,
  output logic                 vld_o,
  output logic [SqW/2-1:0]     root_o,
  output logic [SideW-1:0]     side_o
);

  localparam int RootW = SqW / 2;

  logic [SqW-1:0]   rem  [0:RootW-1];
  logic [RootW-1:0] root [0:RootW];
  logic [SideW-1:0] side [0:RootW];
  logic             vld  [0:RootW];

  assign rem[0]  = sq_i;
  assign root[0] = '0;
  assign side[0] = side_i;
  assign vld[0]  = vld_i;

  for (genvar i = 0; i < RootW; i++) begin : g_stage
    localparam int B = RootW - 1 - i;
    logic [SqW-1:0] trial;
    logic           take;

    // Trial value is (2*root + 2^b) * 2^b; take the bit if it fits the remainder.
    assign trial = (SqW'(root[i]) << (B + 1)) | (SqW'(1) << (2 * B));
    assign take  = rem[i] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[i+1] <= 1'b0;
      end else if (en_i) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root[i+1] <= take ? (root[i] | (RootW'(1) << B)) : root[i];
        side[i+1] <= side[i];
      end
    end

    // The last stage only decides a bit, so it keeps no remainder.
    if (i < RootW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem[i+1] <= take ? (rem[i] - trial) : rem[i];
        end
      end
    end
  end

  assign vld_o  = vld[RootW];
  assign root_o = root[RootW];
  assign side_o = side[RootW];

endmodule

// ===== rtl/mvpt_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined multi-lane divider
// Restoring long division, one quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
module mvpt_div #(
  parameter int Lanes = 3,
  parameter int NumW  = 65,
  parameter int DenW  = 34,
  parameter int QuoW  = 32,
  parameter int SideW = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [Lanes-1:0][NumW-1:0]  num_i,
  input  logic [DenW-1:0]             den_i,
  input  logic [SideW-1:0]            side_i,
  output logic                        vld_o,
  output logic [Lanes-1:0][QuoW-1:0]  quo_o,
  output logic [SideW-1:0]            side_o
);

  // Working width covers the divisor shifted by the top quotient bit.
  localparam int WorkW = DenW + QuoW;

  logic [Lanes-1:0][WorkW-1:0] rem  [0:QuoW-1];
  logic [Lanes-1:0][QuoW-1:0]  quo  [0:QuoW];
  logic [DenW-1:0]             den  [0:QuoW-1];
  logic [SideW-1:0]            side [0:QuoW];
  logic                        vld  [0:QuoW];

  for (genvar l = 0; l < Lanes; l++) begin : g_in
    assign rem[0][l] = WorkW'(num_i[l]);
  end
  assign quo[0]  = '0;
  assign den[0]  = den_i;
  assign side[0] = side_i;
  assign vld[0]  = vld_i;

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    localparam int J = QuoW - 1 - k;
    logic [WorkW-1:0] shd;
    logic [Lanes-1:0] take;

    assign shd = WorkW'(den[k]) << J;

    // Compare each lane against the shifted divisor.
    for (genvar l = 0; l < Lanes; l++) begin : g_lane
      assign take[l] = rem[k][l] >= shd;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo[k+1][l] <= take[l] ? (quo[k][l] | (QuoW'(1) << J)) : quo[k][l];
        end
      end

      if (k < QuoW - 1) begin : g_rem
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            rem[k+1][l] <= take[l] ? (rem[k][l] - shd) : rem[k][l];
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (en_i) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side[k+1] <= side[k];
      end
    end

    if (k < QuoW - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          den[k+1] <= den[k];
        end
      end
    end
  end

  assign vld_o  = vld[QuoW];
  assign quo_o  = quo[QuoW];
  assign side_o = side[QuoW];

endmodule

// ===== tb/move_point_towards_target_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Move point towards target: testbench
// Drives requests with random gaps and random output stalls, predicts each
// result with wide exact integer arithmetic and checks every result in order.
// ----------------------------------------------------------------------------
module move_point_towards_target_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Results expected from the unit, oldest first, with the checking logic.
  class move_scoreboard;
    mvpt_pkg::rsp_t pending_moves[$];
    int   errors;
    int   checked;
    int   reached_cnt;

    // Computes the new point for one request.
    function automatic mvpt_pkg::rsp_t predict_move(mvpt_pkg::req_t rq);
      logic signed [39:0]  cur [3];
      logic signed [39:0]  tgt [3];
      logic signed [39:0]  dif [3];
      logic        [39:0]  ad [3];
      logic signed [39:0]  stp;
      logic        [39:0]  astep;
      logic        [127:0] sq;
      logic        [127:0] root;
      logic        [127:0] cand;
      logic        [127:0] q;
      logic signed [79:0]  sum;
      logic signed [79:0]  lo;
      logic signed [79:0]  hi;
      mvpt_pkg::rsp_t r;
      cur[0] = 40'(rq.cur_x); cur[1] = 40'(rq.cur_y); cur[2] = 40'(rq.cur_z);
      tgt[0] = 40'(rq.tgt_x); tgt[1] = 40'(rq.tgt_y); tgt[2] = 40'(rq.tgt_z);
      stp = 40'(rq.max_step);
      astep = stp < 0 ? -stp : stp;
      sq = '0;
      for (int i = 0; i < 3; i++) begin
        dif[i] = tgt[i] - cur[i];
        ad[i] = dif[i] < 0 ? -dif[i] : dif[i];
        sq += 128'(ad[i]) * 128'(ad[i]);
      end
      if (sq == 0 || (stp >= 0 && sq <= 128'(astep) * 128'(astep))) begin
        r.out_x = rq.tgt_x;
        r.out_y = rq.tgt_y;
        r.out_z = rq.tgt_z;
        r.reached = 1'b1;
        return r;
      end
      // Floor square root, one bit at a time.
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = root | (128'd1 << b);
        if (cand * cand <= sq) root = cand;
      end
      hi = 80'sd2147483647;
      lo = -80'sd2147483648;
      for (int i = 0; i < 3; i++) begin
        q = (128'(ad[i]) * 128'(astep)) / root;
        sum = 80'(cur[i]);
        if ((dif[i] < 0) != (stp < 0)) sum = sum - 80'(q);
        else sum = sum + 80'(q);
        if (sum > hi) sum = hi;
        if (sum < lo) sum = lo;
        case (i)
          0: r.out_x = sum[31:0];
          1: r.out_y = sum[31:0];
          default: r.out_z = sum[31:0];
        endcase
      end
      r.reached = 1'b0;
      return r;
    endfunction

    // Notes an accepted request.
    function void note_request(mvpt_pkg::req_t rq);
      pending_moves.push_back(predict_move(rq));
    endfunction

    // Checks a result against the oldest expectation.
    function void check_result(mvpt_pkg::rsp_t act);
      mvpt_pkg::rsp_t exp_r;
      if (pending_moves.size() == 0) begin
        $error("result with no request waiting: %p", act);
        errors++;
        return;
      end
      exp_r = pending_moves.pop_front();
      checked++;
      if (exp_r.reached) reached_cnt++;
      if (act.out_x !== exp_r.out_x) begin
        $error("out_x expected %0d actual %0d", exp_r.out_x, act.out_x);
        errors++;
      end
      if (act.out_y !== exp_r.out_y) begin
        $error("out_y expected %0d actual %0d", exp_r.out_y, act.out_y);
        errors++;
      end
      if (act.out_z !== exp_r.out_z) begin
        $error("out_z expected %0d actual %0d", exp_r.out_z, act.out_z);
        errors++;
      end
      if (act.reached !== exp_r.reached) begin
        $error("reached expected %0b actual %0b", exp_r.reached, act.reached);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  mvpt_pkg::req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  mvpt_pkg::rsp_t out_rsp_o;

  move_scoreboard sb = new();
  bit   calm_phase = 1'b0;
  int   sent = 0;

  always #5 clk_i = ~clk_i;

  move_point_towards_target_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Accepted requests and results are sampled at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(in_req_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_rsp_o);
    end
  end

  // Random output stall, absent during the calm stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !calm_phase && ($urandom_range(99) < 28);
  end

  // Random coordinate: mostly moderate values, sometimes extremes.
  function automatic mvpt_pkg::coord_t rand_coord();
    case ($urandom_range(9))
      0: return mvpt_pkg::coord_t'(32'h8000_0000);
      1: return mvpt_pkg::coord_t'(32'h7fff_ffff);
      2, 3: return mvpt_pkg::coord_t'($urandom);
      default: return mvpt_pkg::coord_t'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  // Presents one request, with an optional idle gap first, and waits for it.
  task automatic send_request(mvpt_pkg::req_t rq);
    while (!calm_phase && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= rq;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  function automatic mvpt_pkg::req_t make_req(mvpt_pkg::coord_t cx, mvpt_pkg::coord_t cy,
                                              mvpt_pkg::coord_t cz, mvpt_pkg::coord_t tx,
                                              mvpt_pkg::coord_t ty, mvpt_pkg::coord_t tz,
                                              mvpt_pkg::coord_t st);
    mvpt_pkg::req_t rq;
    rq.cur_x = cx; rq.cur_y = cy; rq.cur_z = cz;
    rq.tgt_x = tx; rq.tgt_y = ty; rq.tgt_z = tz;
    rq.max_step = st;
    return rq;
  endfunction

  initial begin
    localparam mvpt_pkg::coord_t MaxC = 32'sh7fff_ffff;
    localparam mvpt_pkg::coord_t MinC = 32'sh8000_0000;
    mvpt_pkg::req_t rq;
    int   r;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: coincident points, zero step, negative step, extremes.
    send_request(make_req(5, 6, 7, 5, 6, 7, -3));
    send_request(make_req(0, 0, 0, 0, 0, 0, MaxC));
    send_request(make_req(0, 0, 0, 65536, 0, 0, 0));
    send_request(make_req(0, 0, 0, 65536, 0, 0, 65536));
    send_request(make_req(0, 0, 0, 65536, 0, 0, 32768));
    send_request(make_req(0, 0, 0, 65536, 65536, 65536, -65536));
    send_request(make_req(MinC, MinC, MinC, MaxC, MaxC, MaxC, MaxC));
    send_request(make_req(MinC, MinC, MinC, MaxC, MaxC, MaxC, MinC));
    send_request(make_req(MaxC, MaxC, MaxC, MinC, MinC, MinC, 1000));
    send_request(make_req(MaxC, MaxC, MaxC, MinC, MinC, MinC, MinC));
    send_request(make_req(MaxC, 0, MinC, MaxC - 1, 0, MinC, -1));
    send_request(make_req(MinC, 0, MaxC, MinC + 1, 0, MaxC, -1));
    send_request(make_req(0, 0, 0, 3, 4, 0, 5));
    send_request(make_req(0, 0, 0, 3, 4, 0, 4));
    send_request(make_req(0, 0, 0, 1, 1, 1, 1));
    send_request(make_req(-1, -1, -1, 0, 0, 0, MinC));
    send_request(make_req(100, -200, 300, -400, 500, -600, MaxC));

    // Random: a calm stretch in the middle with no idling.
    for (int n = 0; n < 1050; n++) begin
      calm_phase = (n >= 400 && n < 550);
      r = $urandom_range(9);
      rq = make_req(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord());
      if (r == 0) begin
        rq.tgt_x = rq.cur_x; rq.tgt_y = rq.cur_y; rq.tgt_z = rq.cur_z;
      end else if (r == 1) begin
        rq.max_step = 0;
      end else if (r == 2) begin
        rq.tgt_x = rq.cur_x + mvpt_pkg::coord_t'($signed($urandom_range(64)) - 32);
        rq.max_step = mvpt_pkg::coord_t'($urandom_range(100));
      end else if (r == 3) begin
        rq.max_step = mvpt_pkg::coord_t'($urandom);
      end
      send_request(rq);
    end
    calm_phase = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.pending_moves.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d results, %0d of them reaching the target.",
             sent, sb.checked, sb.reached_cnt);
    if (sb.errors == 0 && sb.pending_moves.size() == 0) begin
      $display("move_point_towards_target_unit_tb passed");
    end else begin
      $display("move_point_towards_target_unit_tb failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("move_point_towards_target_unit_tb failed");
    $finish;
  end

endmodule
